FILE: hdl/npg_pkg.sv
// Shared types, lookup tables and fixed-point constants of the palette entry generator.
// Depends on nothing; used by npg_sine and ntsc_palette_entry_generator_core.
package npg_pkg;

    typedef logic [9:0]         angle_t;   // half-degrees, 0..719
    typedef logic signed [17:0] trig_t;    // signed Q16, -65536..65536
    typedef logic [16:0]        qsine_t;   // unsigned Q16 magnitude

    typedef enum logic {
        REG_HUE  = 1'b0,
        REG_TINT = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] HUE_RESET  = 8'd72;
    localparam logic [7:0] TINT_RESET = 8'd56;

    localparam int SINE_DEPTH = 181;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_STEP = PI_Q60 / 64'd360;

    // Reciprocals for the final divide: red/blue by 100, green by 5300
    localparam int          RB_DIV    = 100;
    localparam int          G_DIV     = 5300;
    localparam int          RB_SHIFT  = 24;
    localparam int          G_SHIFT   = 34;
    localparam longint      RB_RECIP_L = ((64'sd1 <<< RB_SHIFT) + RB_DIV - 1) / RB_DIV;
    localparam longint      G_RECIP_L  = ((64'sd1 <<< G_SHIFT) + G_DIV - 1) / G_DIV;
    localparam logic [17:0] RB_RECIP  = 18'(RB_RECIP_L);
    localparam logic [21:0] G_RECIP   = 22'(G_RECIP_L);

    // Saturation thresholds of the pre-divide values (255 + 1 times divisor)
    localparam int          RB_LIMIT  = RB_DIV * 256;
    localparam int          G_LIMIT   = G_DIV * 256;

    function automatic logic [5:0] phase_of(input logic [3:0] col);
        logic [5:0] p;
        case (col)
            4'd1:    p = 6'd24;
            4'd2:    p = 6'd21;
            4'd3:    p = 6'd18;
            4'd4:    p = 6'd15;
            4'd5:    p = 6'd12;
            4'd6:    p = 6'd9;
            4'd7:    p = 6'd6;
            4'd8:    p = 6'd3;
            4'd10:   p = 6'd33;
            4'd11:   p = 6'd30;
            4'd12:   p = 6'd27;
            default: p = 6'd0;
        endcase
        return p;
    endfunction

    // Luma in hundredths: gray ramp, dark ramp, main ramp, black
    function automatic logic [6:0] luma_y100(input logic [1:0] lum, input logic [3:0] col);
        logic [6:0] y;
        if (col == 4'd0) begin
            case (lum)
                2'd0:    y = 7'd50;
                2'd1:    y = 7'd75;
                default: y = 7'd100;
            endcase
        end else if (col == 4'd13) begin
            case (lum)
                2'd0:    y = 7'd0;
                2'd1:    y = 7'd24;
                2'd2:    y = 7'd47;
                default: y = 7'd77;
            endcase
        end else if (col > 4'd13) begin
            y = 7'd0;
        end else begin
            case (lum)
                2'd0:    y = 7'd29;
                2'd1:    y = 7'd45;
                2'd2:    y = 7'd73;
                default: y = 7'd90;
            endcase
        end
        return y;
    endfunction

    // round(65536*sin(k half-degrees)), Taylor series in Q60; evaluated at elaboration
    function automatic qsine_t quarter_sine(input int unsigned k);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] prod;
        logic         neg;
        x    = PI_STEP * 64'(k);
        prod = {64'd0, x} * {64'd0, x};
        x2   = prod[123:60];
        term = x;
        sum  = x;
        neg  = 1'b1;
        for (int n = 3; n <= 27; n += 2) begin
            prod = {64'd0, term} * {64'd0, x2};
            term = prod[123:60] / 64'(n * (n - 1));
            sum  = neg ? (sum - term) : (sum + term);
            neg  = !neg;
        end
        sum = sum + (64'd1 << 43);
        return sum[60:44];
    endfunction

endpackage

FILE: hdl/npg_sine.sv
// Signed Q16 sine of an angle in half-degrees: quadrant fold plus quarter-wave table.
// Depends on npg_pkg (types and the table builder).
module npg_sine (
    input  npg_pkg::angle_t angle,
    output npg_pkg::trig_t  value
);

    npg_pkg::qsine_t sine_rom [0:npg_pkg::SINE_DEPTH-1];
    logic [7:0]      idx;
    logic            neg;
    npg_pkg::qsine_t mag;

    for (genvar k = 0; k < npg_pkg::SINE_DEPTH; k++) begin : g_rom
        assign sine_rom[k] = npg_pkg::quarter_sine(k);
    end

    always_comb
    begin
        if (angle < 10'd180) begin
            idx = angle[7:0];
            neg = 1'b0;
        end else if (angle < 10'd360) begin
            idx = 8'(10'd360 - angle);
            neg = 1'b0;
        end else if (angle < 10'd540) begin
            idx = 8'(angle - 10'd360);
            neg = 1'b1;
        end else begin
            idx = 8'(10'd720 - angle);
            neg = 1'b1;
        end
    end

    assign mag   = sine_rom[idx];
    assign value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

FILE: hdl/ntsc_palette_entry_generator_core.sv
// Top level of the palette entry generator: config registers and a five-stage pipeline.
// Depends on npg_pkg and npg_sine.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one palette position per beat:
//   luma_level (row 0..3) and hue_column (column 0..15). Output channel
//   (out_valid/out_ready) returns one beat per input beat, in order:
//   entry_index and the clamped red/green/blue levels.
//   Each accepted beat passes through all five pipeline registers in order
//   before out_valid. Throughput is one beat per cycle unless the receiver stalls; the five
//   pipeline registers (angle, sine/cosine lookup, tint products, pre-divide
//   sums, reciprocal divide and clamp) each hold one beat.
//   When the receiver stalls with a result pending, the whole pipeline holds
//   and in_ready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits and loads hue 72 and tint 56.
//   cfg_write writes cfg_data[7:0] into the register picked by cfg_index
//   (0 hue, 1 tint) at the clock edge; write only while the pipeline is empty.
module ntsc_palette_entry_generator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] luma_level,
    input  logic [3:0] hue_column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] entry_index,
    output logic [7:0] red_level,
    output logic [7:0] green_level,
    output logic [7:0] blue_level
);

    logic [7:0] hue_reg;
    logic [7:0] tint_reg;
    logic       adv;

    // stage 1: angle, luma, tint
    logic            v1_reg;
    npg_pkg::angle_t sin_ang_reg, sin_ang_next;
    npg_pkg::angle_t cos_ang_reg, cos_ang_next;
    logic [6:0]      y1_reg;
    logic [7:0]      t1_reg;
    logic [5:0]      idx1_reg;
    logic [10:0]     ang_sum;
    logic [10:0]     cos_sum;
    logic            chroma_on;

    // stage 2: sine and cosine
    logic            v2_reg;
    npg_pkg::trig_t  s_reg, s_next;
    npg_pkg::trig_t  c_reg, c_next;
    logic [6:0]      y2_reg;
    logic [7:0]      t2_reg;
    logic [5:0]      idx2_reg;

    // stage 3: tint products
    logic               v3_reg;
    logic signed [25:0] pr_reg, pr_next;
    logic signed [25:0] pb_reg, pb_next;
    logic signed [30:0] pg_reg, pg_next;
    logic [6:0]         y3_reg;
    logic [5:0]         idx3_reg;
    logic signed [8:0]  tint_s;
    logic signed [22:0] g_mix;

    // stage 4: pre-divide sums with sign and saturation flags
    logic               v4_reg;
    logic [14:0]        mr_reg, mr_next;
    logic [14:0]        mb_reg, mb_next;
    logic [20:0]        mg_reg, mg_next;
    logic [2:0]         neg_reg, neg_next;
    logic [2:0]         sat_reg, sat_next;
    logic [5:0]         idx4_reg;
    logic signed [32:0] wr;
    logic signed [32:0] wb;
    logic signed [37:0] wg;
    logic signed [18:0] sum_r;
    logic signed [18:0] sum_b;
    logic signed [23:0] sum_g;
    logic [20:0]        base_g;

    // stage 5: divide and clamp (output register)
    logic               v5_reg;
    logic [5:0]         idx5_reg;
    logic [7:0]         red_reg, red_next;
    logic [7:0]         green_reg, green_next;
    logic [7:0]         blue_reg, blue_next;
    logic [32:0]        qr_prod;
    logic [32:0]        qb_prod;
    logic [42:0]        qg_prod;

    assign adv      = !v5_reg || out_ready;
    assign in_ready = adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hue_reg  <= npg_pkg::HUE_RESET;
            tint_reg <= npg_pkg::TINT_RESET;
        end else if (cfg_write) begin
            unique case (npg_pkg::cfg_reg_t'(cfg_index))
                npg_pkg::REG_HUE:  hue_reg  <= cfg_data;
                npg_pkg::REG_TINT: tint_reg <= cfg_data;
                default:           hue_reg  <= hue_reg;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1 ----------------
    assign chroma_on = (hue_column != 4'd0) && (hue_column < 4'd13);
    assign ang_sum   = 11'(npg_pkg::phase_of(hue_column)) * 11'd20 + 11'(hue_reg) + 11'd600;

    always_comb
    begin
        if (ang_sum >= 11'd1440) begin
            sin_ang_next = 10'(ang_sum - 11'd1440);
        end else if (ang_sum >= 11'd720) begin
            sin_ang_next = 10'(ang_sum - 11'd720);
        end else begin
            sin_ang_next = ang_sum[9:0];
        end
    end

    assign cos_sum      = {1'b0, sin_ang_next} + 11'd180;
    assign cos_ang_next = (cos_sum >= 11'd720) ? 10'(cos_sum - 11'd720) : cos_sum[9:0];

    always_ff @(posedge clk)
    begin
        if (adv) begin
            sin_ang_reg <= sin_ang_next;
            cos_ang_reg <= cos_ang_next;
            y1_reg      <= npg_pkg::luma_y100(luma_level, hue_column);
            t1_reg      <= chroma_on ? tint_reg : 8'd0;
            idx1_reg    <= {luma_level, hue_column};
        end
    end

    // ---------------- stage 2 ----------------
    npg_sine u_sin (
        .angle (sin_ang_reg),
        .value (s_next)
    );

    npg_sine u_cos (
        .angle (cos_ang_reg),
        .value (c_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s_reg    <= s_next;
            c_reg    <= c_next;
            y2_reg   <= y1_reg;
            t2_reg   <= t1_reg;
            idx2_reg <= idx1_reg;
        end
    end

    // ---------------- stage 3 ----------------
    assign tint_s  = $signed({1'b0, t2_reg});
    assign g_mix   = 23'sd10 * c_reg - 23'sd27 * s_reg;
    assign pr_next = tint_s * s_reg;
    assign pb_next = tint_s * c_reg;
    assign pg_next = tint_s * g_mix;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            pr_reg   <= pr_next;
            pb_reg   <= pb_next;
            pg_reg   <= pg_next;
            y3_reg   <= y2_reg;
            idx3_reg <= idx2_reg;
        end
    end

    // ---------------- stage 4 ----------------
    // drop 15 fraction bits (floor), then add the luma term
    assign wr     = 33'sd100 * pr_reg;
    assign wb     = -(33'sd100 * pb_reg);
    assign wg     = 38'sd100 * pg_reg;
    assign base_g = 21'(y3_reg) * 21'd13568;
    assign sum_r  = $signed({4'd0, y3_reg, 8'd0}) + $signed({wr[32], wr[32:15]});
    assign sum_b  = $signed({4'd0, y3_reg, 8'd0}) + $signed({wb[32], wb[32:15]});
    assign sum_g  = $signed({3'd0, base_g}) + $signed({wg[37], wg[37:15]});

    always_comb
    begin
        neg_next = {sum_b[18], sum_g[23], sum_r[18]};
        sat_next[0] = !sum_r[18] && (sum_r >= 19'sd25600);
        sat_next[1] = !sum_g[23] && (sum_g >= 24'sd1356800);
        sat_next[2] = !sum_b[18] && (sum_b >= 19'sd25600);
        mr_next = sum_r[14:0];
        mg_next = sum_g[20:0];
        mb_next = sum_b[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            mr_reg   <= mr_next;
            mg_reg   <= mg_next;
            mb_reg   <= mb_next;
            neg_reg  <= neg_next;
            sat_reg  <= sat_next;
            idx4_reg <= idx3_reg;
        end
    end

    // ---------------- stage 5 ----------------
    assign qr_prod = 33'(mr_reg) * 33'(npg_pkg::RB_RECIP);
    assign qb_prod = 33'(mb_reg) * 33'(npg_pkg::RB_RECIP);
    assign qg_prod = 43'(mg_reg) * 43'(npg_pkg::G_RECIP);

    always_comb
    begin
        red_next   = neg_reg[0] ? 8'd0 : (sat_reg[0] ? 8'd255
                   : qr_prod[npg_pkg::RB_SHIFT +: 8]);
        green_next = neg_reg[1] ? 8'd0 : (sat_reg[1] ? 8'd255
                   : qg_prod[npg_pkg::G_SHIFT +: 8]);
        blue_next  = neg_reg[2] ? 8'd0 : (sat_reg[2] ? 8'd255
                   : qb_prod[npg_pkg::RB_SHIFT +: 8]);
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            idx5_reg  <= idx4_reg;
        end
    end

    assign out_valid   = v5_reg;
    assign entry_index = idx5_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

`ifndef ASSERT_OFF
    // gray and no-chroma columns must come out as equal channels
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_index[3:0] == 4'd0 || entry_index[3:0] == 4'd13)
        |-> (red_level == green_level) && (green_level == blue_level))
        else $error("gray column produced unequal channels");

    // black columns must be all zero
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_index[3:0] == 4'd14 || entry_index[3:0] == 4'd15)
        |-> (red_level == 8'd0) && (green_level == 8'd0) && (blue_level == 8'd0))
        else $error("black column produced nonzero channel");

    // a beat accepted with no stall behind it reaches the output with its own index
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 adv ##1 adv ##1 adv ##1 adv
        |=> out_valid && (entry_index == $past({luma_level, hue_column}, 5)))
        else $error("accepted beat did not reach the output in order");
`endif

endmodule
